>>> src/bbd_pkg.sv
// ----------------------------------------------------------------------------
// Black border detect package
// Shared sizes, reset values, configuration codes and the types that pass
// between the configuration block, the probe unit and the top level.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int MaxProbes  = 16;
  localparam int MaxDim     = 4096;
  localparam int DimW       = $clog2(MaxDim);
  localparam int CfgW       = 12;
  localparam int RowW       = 10;
  localparam int PidxW      = $clog2(MaxProbes);
  localparam int PcntW      = $clog2(MaxProbes + 1);
  localparam int NpcW       = DimW + 1;
  localparam int OffW       = DimW + PcntW;
  localparam int CfgIdxW    = 1;

  localparam int WidthRst   = 1920;
  localparam int HeightRst  = 1080;

  // floor(w / 10) == (w * 3277) >> 15 for every w below 2**CfgW
  localparam int RecipMul   = 3277;
  localparam int RecipShift = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0] spacing;
    logic [DimW-1:0] w_last;
    logic [DimW-1:0] h_last;
    logic [DimW-1:0] row_limit;
  } cfg_t;

  typedef struct packed {
    logic frame_start;
    logic nonzero;
  } pix_t;

  typedef struct packed {
    logic            last;
    logic [RowW-1:0] border_rows;
    logic            agree;
  } res_t;

endpackage

>>> src/bbd_cfg.sv
// ----------------------------------------------------------------------------
// Black border detect configuration
// Holds frame width and height in the derived form the probe unit needs:
// probe spacing, last column, last row and the scanned row limit.
// ----------------------------------------------------------------------------
module bbd_cfg
  import bbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t              cfg_q;
  logic [CfgW-1:0]   eff;
  logic [2*CfgW-1:0] prod;
  logic [DimW-1:0]   quot;

  always_comb begin
    eff  = (cfg_wdata_i == '0) ? CfgW'(1) : cfg_wdata_i;
    prod = (2*CfgW)'(eff) * (2*CfgW)'(RecipMul);
    quot = DimW'(prod >> RecipShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spacing   <= DimW'(WidthRst / 10);
      cfg_q.w_last    <= DimW'(WidthRst - 1);
      cfg_q.h_last    <= DimW'(HeightRst - 1);
      cfg_q.row_limit <= DimW'(HeightRst / 4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFrameWidth: begin
          cfg_q.spacing <= (quot == '0) ? DimW'(1) : quot;
          cfg_q.w_last  <= DimW'(eff) - DimW'(1);
        end
        CfgFrameHeight: begin
          cfg_q.h_last    <= DimW'(eff) - DimW'(1);
          cfg_q.row_limit <= DimW'(eff >> 2);
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/bbd_probe.sv
// ----------------------------------------------------------------------------
// Black border detect probe unit
// Tracks the raster position, records the first lit row at each probe
// column and forms the agreement result on the last pixel of a frame.
// ----------------------------------------------------------------------------
module bbd_probe
  import bbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  pix_t pix_i,
  input  logic pix_go_i,
  output res_t res_o
);

  logic [DimW-1:0]      col_q, col_d, col;
  logic [DimW-1:0]      row_q, row_d, row;
  logic [NpcW-1:0]      npc_q, npc_d, npc;
  logic [PcntW-1:0]     pidx_q, pidx_d, pidx;
  logic [MaxProbes-1:0] found_q, found_eff, found_d;
  logic [RowW-1:0]      first_q [MaxProbes];
  logic [RowW-1:0]      first_d [MaxProbes];
  logic [RowW-1:0]      val     [MaxProbes];
  logic [PidxW-1:0]     idx;
  logic                 hit, take, wr, sel, last_col, last, mismatch, active;
  logic [OffW-1:0]      offs;

  always_comb begin
    col       = pix_i.frame_start ? '0 : col_q;
    row       = pix_i.frame_start ? '0 : row_q;
    npc       = pix_i.frame_start ? '0 : npc_q;
    pidx      = pix_i.frame_start ? '0 : pidx_q;
    found_eff = pix_i.frame_start ? '0 : found_q;
    idx       = pidx[PidxW-1:0];

    hit  = (NpcW'(col) == npc);
    take = hit && (pidx < PcntW'(MaxProbes));
    wr   = take && (row < cfg_i.row_limit) && pix_i.nonzero && !found_eff[idx];

    mismatch = 1'b0;
    for (int k = 0; k < MaxProbes; k++) begin
      sel         = wr && (idx == PidxW'(k));
      found_d[k]  = found_eff[k] | sel;
      first_d[k]  = sel ? row[RowW-1:0] : first_q[k];
      val[k]      = found_d[k] ? first_d[k] : '0;
      offs        = OffW'(k) * OffW'(cfg_i.spacing);
      active      = (offs <= OffW'(cfg_i.w_last));
      mismatch    = mismatch | (active && (val[k] != val[0]));
    end

    last_col = (col >= cfg_i.w_last);
    last     = last_col && (row >= cfg_i.h_last);

    npc_d  = hit  ? npc + NpcW'(cfg_i.spacing) : npc;
    pidx_d = take ? pidx + PcntW'(1) : pidx;
    row_d  = row;
    col_d  = col + DimW'(1);
    if (last_col) begin
      col_d  = '0;
      row_d  = last ? '0 : row + DimW'(1);
      npc_d  = '0;
      pidx_d = '0;
    end

    res_o.last        = last;
    res_o.agree       = !mismatch;
    res_o.border_rows = mismatch ? '0 : val[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      npc_q   <= '0;
      pidx_q  <= '0;
      found_q <= '0;
    end else if (pix_go_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      npc_q   <= npc_d;
      pidx_q  <= pidx_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_go_i) begin
      first_q <= first_d;
    end
  end

  a_pidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pidx_q <= PcntW'(MaxProbes))
    else $error("probe index past probe count");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_go_i && pix_i.frame_start) |=> ($countones(found_q) <= 1))
    else $error("probe store not cleared at frame start");

endmodule

>>> src/top_black_border_detect.sv
// ----------------------------------------------------------------------------
// Top black border detect
// Finds the height of a black bar at the top of a frame from probe columns.
//
// Pixels enter on the input channel (in_valid_i / in_stall_o) one beat per
// pixel, in raster order, with frame_start_i marking the first pixel of a
// frame. Each beat is held in an input register and processed from there;
// the block takes one pixel every clock cycle unless the input stalls.
// On the last pixel of a frame one result beat leaves on the output channel
// (out_valid_o / out_stall_i); it is loaded into the output register when
// that pixel is processed from the input register. The output
// register holds a result while the receiver stalls; pixels keep flowing,
// and the input stalls only when a second frame result is ready while the
// first is still held.
// Width (register 0) and height (register 1) come through the plain write
// port; the user must write them only while the block is idle (unchecked).
// Reset loads a 1920 x 1080 frame size, clears the position counters and
// the probe store and empties both registers.
// ----------------------------------------------------------------------------
module top_black_border_detect
  import bbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               frame_start_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RowW-1:0]    border_rows_o,
  output logic               probes_agree_o
);

  cfg_t            cfg;
  res_t            res;
  pix_t            pix_q;
  logic            pix_valid_q, pix_valid_d;
  logic            out_valid_q, out_valid_d;
  logic [RowW-1:0] border_q;
  logic            agree_q;
  logic            go, in_acc, out_load;

  bbd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bbd_probe u_probe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .pix_i    (pix_q),
    .pix_go_i (go),
    .res_o    (res)
  );

  always_comb begin
    go          = pix_valid_q && !(res.last && out_valid_q && out_stall_i);
    in_stall_o  = pix_valid_q && !go;
    in_acc      = in_valid_i && !in_stall_o;
    out_load    = go && res.last;
    pix_valid_d = in_acc ? 1'b1 : (go ? 1'b0 : pix_valid_q);
    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pix_valid_q <= pix_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q.frame_start <= frame_start_i;
      pix_q.nonzero     <= ((red_i | green_i | blue_i) != 8'd0);
    end
    if (out_load) begin
      border_q <= res.border_rows;
      agree_q  <= res.agree;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign border_rows_o  = border_q;
  assign probes_agree_o = agree_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pix_valid_q)
    else $error("input stalled with empty input register");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(go && res.last))
    else $error("result beat without a last pixel");

  a_disagree_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !agree_q) |-> (border_q == '0))
    else $error("nonzero border on disagreeing probes");

endmodule

>>> bench/tb_top_black_border_detect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Black border detect testbench
// Streams synthetic frames (black, top bar, ragged bar, noise) through the
// block and checks every border result against a probe-column tracker kept
// in the bench or, for the first result of a directed step, a table value.
// A short table of directed steps covers the size extremes, narrow and short
// frames, wrapping without frame start and size changes between rows;
// random frames follow under varying sender and receiver pacing.
// ----------------------------------------------------------------------------
module tb_top_black_border_detect;
  import bbd_pkg::*;

  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int unsigned TailLimit    = 5_000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandFrames   = 5;
  localparam int unsigned PlanSteps    = 15;

  typedef enum {PaceFree, PaceSendGaps, PaceRecvStalls, PaceBoth} pace_e;
  typedef enum {SceneBlack, SceneBar, SceneRagged, SceneNoise} scene_e;
  typedef enum {ChanAll, ChanRed, ChanGreen, ChanBlue} chan_e;

  typedef struct packed {
    logic [RowW-1:0] rows;
    logic            agree;
  } border_t;

  typedef struct {
    logic            wr_w;
    logic [CfgW-1:0] w;
    logic            wr_h;
    logic [CfgW-1:0] h;
    scene_e          scn;
    int unsigned     bar;
    chan_e           chan;
    logic [7:0]      lit;
    int unsigned     rows;
    logic            fs;
    logic            typed;
    logic [RowW-1:0] exp_rows;
    logic            exp_agree;
  } step_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i      = '0;
  logic [CfgW-1:0]    cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               frame_start_i  = 1'b0;
  logic [7:0]         red_i          = '0;
  logic [7:0]         green_i        = '0;
  logic [7:0]         blue_i         = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [RowW-1:0]    border_rows_o;
  logic               probes_agree_o;

  top_black_border_detect u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_start_i  (frame_start_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .border_rows_o  (border_rows_o),
    .probes_agree_o (probes_agree_o)
  );

  always #4 clk_i = ~clk_i;

  // Tracker state: frame size, raster position and probe store
  logic [CfgW-1:0] cfg_w = CfgW'(WidthRst);
  logic [CfgW-1:0] cfg_h = CfgW'(HeightRst);
  int unsigned     col_pos    = 0;
  int unsigned     row_pos    = 0;
  int unsigned     next_probe = 0;
  int unsigned     probe_no   = 0;
  logic [RowW-1:0] probe_row [MaxProbes];
  logic            probe_hit [MaxProbes];

  border_t     pending_borders [$];
  border_t     pinned_border;
  logic        pinned_on = 1'b0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  scene_e      scene   = SceneBlack;
  chan_e       chan    = ChanAll;
  logic [7:0]  lit     = '0;
  int unsigned bar_row = 0;
  int unsigned jag [8];
  int unsigned draw_row = 0;

  initial begin
    for (int i = 0; i < MaxProbes; i++) begin
      probe_row[i] = '0;
      probe_hit[i] = 1'b0;
    end
  end

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t %s", $time, msg);
  endfunction

  function automatic void track_pixel(input logic fs, input logic [7:0] r, g, b);
    int unsigned w, h, s, lim, v0, v, col;
    logic        agree;
    border_t     res;
    w   = (cfg_w == 0) ? 1 : cfg_w;
    h   = (cfg_h == 0) ? 1 : cfg_h;
    s   = w / 10;
    if (s == 0) s = 1;
    lim = h / 4;
    if (fs) begin
      for (int i = 0; i < MaxProbes; i++) begin
        probe_row[i] = '0;
        probe_hit[i] = 1'b0;
      end
      col_pos    = 0;
      row_pos    = 0;
      next_probe = 0;
      probe_no   = 0;
    end
    if (col_pos == next_probe) begin
      if (probe_no < MaxProbes) begin
        if (row_pos < lim && (r | g | b) != 0 && !probe_hit[probe_no]) begin
          probe_hit[probe_no] = 1'b1;
          probe_row[probe_no] = row_pos[RowW-1:0];
        end
        probe_no++;
      end
      next_probe += s;
    end
    if (col_pos >= w - 1) begin
      if (row_pos >= h - 1) begin
        v0    = probe_hit[0] ? probe_row[0] : 0;
        agree = 1'b1;
        col   = 0;
        for (int k = 0; k < MaxProbes && col < w; k++) begin
          v = probe_hit[k] ? probe_row[k] : 0;
          if (v != v0) agree = 1'b0;
          col += s;
        end
        res.rows  = agree ? v0[RowW-1:0] : '0;
        res.agree = agree;
        if (pinned_on) begin
          res       = pinned_border;
          pinned_on = 1'b0;
        end
        pending_borders.push_back(res);
        row_pos = 0;
      end else begin
        row_pos++;
      end
      col_pos    = 0;
      next_probe = 0;
      probe_no   = 0;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic void check_border(input logic [RowW-1:0] rows, input logic agree);
    border_t want;
    if (pending_borders.size() == 0) begin
      flag($sformatf("unexpected border beat: rows %0d agree %0b", rows, agree));
    end else begin
      want = pending_borders.pop_front();
      if (rows !== want.rows || agree !== want.agree)
        flag($sformatf("border mismatch: rows exp %0d got %0d, agree exp %0b got %0b",
                       want.rows, rows, want.agree, agree));
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_border(border_rows_o, probes_agree_o);
      if (in_valid_i && !in_stall_o) track_pixel(frame_start_i, red_i, green_i, blue_i);
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void set_pace(input pace_e p);
    case (p)
      PaceSendGaps: begin
        send_gap_pct   = 53;
        recv_stall_pct = 0;
      end
      PaceRecvStalls: begin
        send_gap_pct   = 0;
        recv_stall_pct = 53;
      end
      PaceBoth: begin
        send_gap_pct   = 7;
        recv_stall_pct = 7;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  function automatic int unsigned rows_per_frame();
    return (cfg_h == 0) ? 1 : cfg_h;
  endfunction

  function automatic void load_scene(input scene_e scn, input int unsigned bar,
                                     input chan_e ch, input logic [7:0] level);
    scene   = scn;
    bar_row = bar;
    chan    = ch;
    lit     = level;
    for (int i = 0; i < 8; i++) jag[i] = $urandom_range(0, 1);
  endfunction

  function automatic logic [23:0] scene_pixel(input int unsigned row, input int unsigned col);
    logic        lit_up;
    logic [7:0]  v;
    logic [23:0] px;
    case (scene)
      SceneBlack:  lit_up = 1'b0;
      SceneBar:    lit_up = (row >= bar_row);
      SceneRagged: lit_up = (row >= bar_row + jag[col % 8]);
      default:     lit_up = ($urandom_range(0, 5) == 0);
    endcase
    v = (lit != 0) ? lit : 8'($urandom_range(1, 255));
    case (chan)
      ChanRed:   px = {v, 16'h0000};
      ChanGreen: px = {8'h00, v, 8'h00};
      ChanBlue:  px = {16'h0000, v};
      default: begin
        px = (lit != 0) ? {3{v}} : 24'($urandom());
        if (px == 0) px = {v, 16'h0000};
      end
    endcase
    return lit_up ? px : 24'h000000;
  endfunction

  task automatic push_pixel(input logic fs, input logic [23:0] px);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frame_start_i <= fs;
    red_i         <= px[23:16];
    green_i       <= px[15:8];
    blue_i        <= px[7:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic stream_rows(input int unsigned n_rows, input logic with_start);
    int unsigned width;
    width = (cfg_w == 0) ? 1 : cfg_w;
    if (with_start) draw_row = 0;
    for (int unsigned r = 0; r < n_rows; r++) begin
      for (int unsigned c = 0; c < width; c++)
        push_pixel(with_start && r == 0 && c == 0, scene_pixel(draw_row, c));
      draw_row++;
    end
  endtask

  // Hold the input until every border beat is back and the pipeline is empty
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_borders.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_frame(input logic do_w, input logic [CfgW-1:0] w,
                           input logic do_h, input logic [CfgW-1:0] h);
    wait_quiet();
    if (do_w) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CfgFrameWidth;
      cfg_wdata_i <= w;
      @(posedge clk_i);
      cfg_w = w;
    end
    if (do_h) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CfgFrameHeight;
      cfg_wdata_i <= h;
      @(posedge clk_i);
      cfg_h = h;
    end
    cfg_we_i <= 1'b0;
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    step_t       plan [PlanSteps];
    int unsigned heff, k, hn, tail;

    plan = '{
      // 100 x 4 frame, all black
      '{1'b1, 12'd100,  1'b1, 12'd4,    SceneBlack,  0,   ChanAll,   8'h00, 4,   1'b1,
        1'b1, 10'd0,    1'b1},
      // single-channel, full-colour and ragged bars in narrow frames
      '{1'b1, 12'd10,   1'b1, 12'd4,    SceneBar,    0,   ChanRed,   8'hFF, 4,   1'b1,
        1'b1, 10'd0,    1'b1},
      '{1'b0, 12'd10,   1'b1, 12'd8,    SceneBar,    1,   ChanGreen, 8'h01, 8,   1'b1,
        1'b1, 10'd1,    1'b1},
      '{1'b0, 12'd10,   1'b0, 12'd8,    SceneBar,    1,   ChanBlue,  8'h80, 8,   1'b1,
        1'b1, 10'd1,    1'b1},
      '{1'b0, 12'd10,   1'b0, 12'd8,    SceneBar,    2,   ChanAll,   8'h00, 8,   1'b1,
        1'b1, 10'd0,    1'b1},
      '{1'b0, 12'd10,   1'b0, 12'd8,    SceneRagged, 0,   ChanAll,   8'h00, 8,   1'b1,
        1'b0, 10'd0,    1'b0},
      // narrow rows: more probe columns than the store keeps
      '{1'b1, 12'd19,   1'b1, 12'd4,    SceneRagged, 0,   ChanAll,   8'h00, 4,   1'b1,
        1'b0, 10'd0,    1'b0},
      // zero width and height: every pixel closes a frame; then a 5 x 2 frame
      '{1'b1, 12'd0,    1'b1, 12'd0,    SceneNoise,  0,   ChanAll,   8'h00, 6,   1'b1,
        1'b0, 10'd0,    1'b0},
      '{1'b1, 12'd5,    1'b1, 12'd2,    SceneBar,    0,   ChanAll,   8'h00, 4,   1'b1,
        1'b0, 10'd0,    1'b0},
      // shrink the height between rows
      '{1'b1, 12'd10,   1'b1, 12'd12,   SceneBar,    2,   ChanAll,   8'h00, 3,   1'b1,
        1'b0, 10'd0,    1'b0},
      '{1'b0, 12'd10,   1'b1, 12'd4,    SceneBar,    2,   ChanAll,   8'h00, 1,   1'b0,
        1'b0, 10'd0,    1'b0},
      '{1'b0, 12'd10,   1'b1, 12'd8,    SceneBar,    1,   ChanAll,   8'h00, 8,   1'b1,
        1'b1, 10'd1,    1'b1},
      // wrap into the next frame without a frame start
      '{1'b0, 12'd10,   1'b0, 12'd8,    SceneBar,    1,   ChanAll,   8'h00, 8,   1'b0,
        1'b0, 10'd0,    1'b0},
      // deep scan, then cut the frame short between rows
      '{1'b1, 12'd1,    1'b1, 12'd4095, SceneBar,    300, ChanAll,   8'h00, 301, 1'b1,
        1'b0, 10'd0,    1'b0},
      '{1'b0, 12'd1,    1'b1, 12'd302,  SceneBar,    300, ChanAll,   8'h00, 1,   1'b0,
        1'b0, 10'd0,    1'b0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PlanSteps; i++) begin
      set_pace(pace_e'(i % 4));
      set_frame(plan[i].wr_w, plan[i].w, plan[i].wr_h, plan[i].h);
      load_scene(plan[i].scn, plan[i].bar, plan[i].chan, plan[i].lit);
      if (plan[i].typed) begin
        pinned_border.rows  = plan[i].exp_rows;
        pinned_border.agree = plan[i].exp_agree;
        pinned_on           = 1'b1;
      end
      stream_rows(plan[i].rows, plan[i].fs);
    end

    for (int f = 0; f < RandFrames; f++) begin
      set_pace(pace_e'(f % 4));
      if (f == 0 || $urandom_range(0, 1) == 0)
        set_frame(1'b1, 12'($urandom_range(10, 20)), 1'b1, 12'($urandom_range(4, 6)));
      heff = rows_per_frame();
      load_scene(scene_e'($urandom_range(0, 3)), $urandom_range(0, heff / 4 + 1),
                 chan_e'($urandom_range(0, 3)),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      case ($urandom_range(0, 9))
        0: stream_rows($urandom_range(1, heff - 1), 1'b1);
        1: stream_rows(heff, 1'b0);
        2: begin
          k = $urandom_range(1, heff - 1);
          stream_rows(k, 1'b1);
          set_frame(1'($urandom_range(0, 1)), 12'($urandom_range(10, 20)),
                    1'b1, 12'($urandom_range(4, 6)));
          hn = rows_per_frame();
          stream_rows((k >= hn - 1) ? 1 : hn - k, 1'b0);
        end
        default: stream_rows(heff, 1'b1);
      endcase
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    tail = 0;
    while (pending_borders.size() != 0 && tail < TailLimit) begin
      @(posedge clk_i);
      tail++;
    end
    repeat (4 * SettleCycles) @(posedge clk_i);
    if (pending_borders.size() != 0)
      flag($sformatf("%0d border beats never arrived", pending_borders.size()));

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/bbd_pkg.sv
src/bbd_cfg.sv
src/bbd_probe.sv
src/top_black_border_detect.sv
bench/tb_top_black_border_detect.sv
